@@ src/tick_sample_position_mapper_assert.svh @@
// ----------------------------------------------------------------------------
// Tick sample position mapper assertion macros
// Shared assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef TICK_SAMPLE_POSITION_MAPPER_ASSERT_SVH
`define TICK_SAMPLE_POSITION_MAPPER_ASSERT_SVH

// Check a consequence in the same cycle as its cause
`define TSPM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause
`define TSPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/tspm_pkg.sv @@
// ----------------------------------------------------------------------------
// Tick sample position mapper package
// Request and result types, operation codes, sequencer states and widths.
// ----------------------------------------------------------------------------
package tspm_pkg;

  // Field widths
  localparam int unsigned POS_W   = 64;
  localparam int unsigned RATIO_W = 20;
  localparam int unsigned RATE_W  = 20;
  localparam int unsigned CNT_W   = $clog2(POS_W);

  // Ticks per second of the tick index
  localparam int unsigned TICK_RATE = 1000;
  // Remainder width of the rate divider, remainder stays below TICK_RATE
  localparam int unsigned TR_W = $clog2(TICK_RATE) + 1;
  localparam logic [TR_W:0] TICK_RATE_C = (TR_W + 1)'(TICK_RATE);

  // Ratio after reset
  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(48);

  // Operation codes
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_TICKS  = 2'd1;
  localparam logic [1:0] KIND_REBASE = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [POS_W-1:0] position;
    logic [RATE_W-1:0]       new_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] value;
    logic                    accepted;
  } out_item_t;

endpackage

@@ src/tick_sample_position_mapper.sv @@
// ----------------------------------------------------------------------------
// Tick sample position mapper
// Maps tick indices to sample positions and back around a stored anchor,
// and moves the anchor on a rebase request. Multiply and divide run one
// bit per cycle through shift registers.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  in        input      in_valid/in_stall   in_item  (tspm_pkg::in_item_t)
//  out       output     out_valid/out_stall out_item (tspm_pkg::out_item_t)
//  cfg       input      cfg_we              cfg_wdata (ratio loaded at once)
//
//  Sample-for-tick, ticks-reached and rebase requests run from acceptance
//  through the bit-serial multiply or the restoring divide, one bit of the
//  64-bit operand per cycle, to a registered result; an unused kind goes
//  straight to the final step. The next request is accepted the cycle after
//  the result is registered, so no request is taken while one is in work.
//  A stalled result holds the block in its final step. rst is synchronous
//  and loads the anchor with zero and the ratio with 48.
// ----------------------------------------------------------------------------
`include "tick_sample_position_mapper_assert.svh"

module tick_sample_position_mapper (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tspm_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output tspm_pkg::out_item_t                out_item,
  input  logic                               cfg_we,
  input  logic [tspm_pkg::RATIO_W-1:0]       cfg_wdata
);

  localparam logic [tspm_pkg::CNT_W-1:0] CNT_LAST = tspm_pkg::CNT_W'(tspm_pkg::POS_W - 1);
  localparam logic [tspm_pkg::CNT_W-1:0] CNT_RATE = tspm_pkg::CNT_W'(tspm_pkg::RATE_W);

  tspm_pkg::state_t state, state_next;

  // Architectural state
  logic [tspm_pkg::POS_W-1:0]   anchor_sample;
  logic [tspm_pkg::POS_W-1:0]   anchor_tick;
  logic [tspm_pkg::RATIO_W-1:0] ratio;

  // Request registers
  logic [1:0]                   kind_q;
  logic [tspm_pkg::POS_W-1:0]   pos_q;
  logic                         less_q;
  logic [tspm_pkg::CNT_W-1:0]   cnt;

  // Serial datapath
  logic [tspm_pkg::POS_W-1:0]   work;
  logic [tspm_pkg::POS_W-1:0]   prod;
  logic [tspm_pkg::RATIO_W:0]   hi;
  logic [tspm_pkg::RATIO_W-1:0] rem;
  logic [tspm_pkg::RATE_W-1:0]  rate_q;
  logic [tspm_pkg::TR_W-1:0]    rrem;

  logic                         in_fire;
  logic                         done_fire;
  logic [tspm_pkg::POS_W-1:0]   sub_b;
  logic [tspm_pkg::POS_W-1:0]   diff;
  logic                         less;
  logic [tspm_pkg::RATIO_W+1:0] mt;
  logic [tspm_pkg::RATIO_W:0]   dt;
  logic [tspm_pkg::RATIO_W:0]   dsub;
  logic                         dge;
  logic [tspm_pkg::TR_W:0]      rt;
  logic [tspm_pkg::TR_W:0]      rsub;
  logic                         rge;
  logic                         rebase_ok;
  logic [tspm_pkg::POS_W-1:0]   qterm;
  tspm_pkg::out_item_t          result;

  assign in_fire   = in_valid && !in_stall;
  assign done_fire = (state == tspm_pkg::ST_DONE) && (!out_valid || !out_stall);

  // Offset of the request position from the matching anchor
  assign sub_b = (in_item.kind == tspm_pkg::KIND_TICKS) ? anchor_sample : anchor_tick;
  assign diff  = in_item.position - sub_b;
  assign less  = $signed(in_item.position) < $signed(sub_b);

  // Multiply step: add the ratio for one offset bit and one anchor bit, emit the low bit
  assign mt = {1'b0, hi}
            + {2'b00, ratio & {tspm_pkg::RATIO_W{work[0]}}}
            + {{(tspm_pkg::RATIO_W + 1){1'b0}}, prod[0]};

  // Divide step: restoring division by the ratio, dividend MSB first
  assign dt   = {rem, work[tspm_pkg::POS_W-1]};
  assign dsub = dt - {1'b0, ratio};
  assign dge  = dt >= {1'b0, ratio};

  // Rate step: restoring division of the new rate by the tick rate
  assign rt   = {rrem, rate_q[tspm_pkg::RATE_W-1]};
  assign rsub = rt - tspm_pkg::TICK_RATE_C;
  assign rge  = rt >= tspm_pkg::TICK_RATE_C;

  // Rebase needs a nonzero whole multiple of the tick rate at or after the anchor
  assign rebase_ok = (kind_q == tspm_pkg::KIND_REBASE) && !less_q
                  && (rrem == '0) && (rate_q != '0);

  // Tick offset: one back before the anchor, zero for a zero ratio
  always_comb begin
    if (less_q) begin
      qterm = '1;
    end else if (ratio == '0) begin
      qterm = '0;
    end else begin
      qterm = work;
    end
  end

  // Form the result
  always_comb begin
    result.value    = '0;
    result.accepted = 1'b0;
    case (kind_q)
      tspm_pkg::KIND_SAMPLE: begin
        result.value    = prod;
        result.accepted = 1'b1;
      end
      tspm_pkg::KIND_TICKS: begin
        result.value    = anchor_tick + qterm;
        result.accepted = 1'b1;
      end
      tspm_pkg::KIND_REBASE: begin
        result.accepted = rebase_ok;
      end
      default: begin
        result.accepted = 1'b0;
      end
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tspm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      tspm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_item.kind)
            tspm_pkg::KIND_SAMPLE: state_next = tspm_pkg::ST_MUL;
            tspm_pkg::KIND_REBASE: state_next = tspm_pkg::ST_MUL;
            tspm_pkg::KIND_TICKS:  state_next = tspm_pkg::ST_DIV;
            default:               state_next = tspm_pkg::ST_DONE;
          endcase
        end
      end
      tspm_pkg::ST_MUL: begin
        if (cnt == CNT_LAST) begin
          state_next = tspm_pkg::ST_DONE;
        end
      end
      tspm_pkg::ST_DIV: begin
        if (cnt == CNT_LAST) begin
          state_next = tspm_pkg::ST_DONE;
        end
      end
      tspm_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = tspm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tspm_pkg::ST_IDLE;
      end
    endcase
  end

  // Load a request, then advance the serial datapath one bit per cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_q <= in_item.kind;
      pos_q  <= in_item.position;
      rate_q <= in_item.new_rate;
      less_q <= less;
      work   <= diff;
      prod   <= anchor_sample;
      hi     <= '0;
      rem    <= '0;
      rrem   <= '0;
      cnt    <= '0;
    end else if (state == tspm_pkg::ST_MUL) begin
      work <= {1'b0, work[tspm_pkg::POS_W-1:1]};
      prod <= {mt[0], prod[tspm_pkg::POS_W-1:1]};
      hi   <= mt[tspm_pkg::RATIO_W+1:1];
      cnt  <= cnt + 1'b1;
      if (cnt < CNT_RATE) begin
        rrem   <= rge ? rsub[tspm_pkg::TR_W-1:0] : rt[tspm_pkg::TR_W-1:0];
        rate_q <= {rate_q[tspm_pkg::RATE_W-2:0], rge};
      end
    end else if (state == tspm_pkg::ST_DIV) begin
      work <= {work[tspm_pkg::POS_W-2:0], dge};
      rem  <= dge ? dsub[tspm_pkg::RATIO_W-1:0] : dt[tspm_pkg::RATIO_W-1:0];
      cnt  <= cnt + 1'b1;
    end
  end

  // Update the anchor and ratio on a good rebase; a config write loads the ratio and wins over a rebase
  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_sample <= '0;
      anchor_tick   <= '0;
      ratio         <= tspm_pkg::RATIO_RESET;
    end else if (cfg_we) begin
      ratio <= cfg_wdata;
    end else if (done_fire && rebase_ok) begin
      anchor_sample <= prod;
      anchor_tick   <= pos_q;
      ratio         <= rate_q;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_item <= result;
    end
  end

  // Assertions
  `TSPM_ASSERT_NEXT(a_busy_after_request, in_fire, state != tspm_pkg::ST_IDLE, "request not taken into work")
  `TSPM_ASSERT_NEXT(a_mul_ends, (state == tspm_pkg::ST_MUL) && (cnt == CNT_LAST), state == tspm_pkg::ST_DONE, "multiply did not end after last bit")
  `TSPM_ASSERT_NEXT(a_result_only_from_done, (state != tspm_pkg::ST_DONE) && !(out_valid && out_stall), !out_valid, "result shown without a finished request")
  `TSPM_ASSERT_SAME(a_rem_below_ratio, (state == tspm_pkg::ST_DIV) && (ratio != '0), rem < ratio, "divide remainder reached the ratio")

endmodule
